// ===== src/fvn_pkg.sv =====
// Package for the fractal value noise block: widths, register indexes,
// hash constants and the item bundle passed from octave cell to octave cell.
// No dependencies.
package fvn_pkg;

	localparam int MAX_OCTAVES = 8;

	localparam int COORD_W    = 32;
	localparam int NOISE_W    = 16;
	localparam int OCT_W      = 4;
	localparam int RATE_W     = 16;
	localparam int SEED_W     = 32;
	localparam int FREQ_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int AMP_W      = FRAC_W + 1;
	localparam int SUM_W      = 2 * FRAC_W + $clog2(MAX_OCTAVES);
	localparam int NORM_W     = AMP_W + $clog2(MAX_OCTAVES);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LACUNARITY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 2'd3;

	// Reset values
	localparam logic [OCT_W-1:0]  OCTAVE_COUNT_RST = 4'd4;
	localparam logic [RATE_W-1:0] LACUNARITY_RST   = 16'd8192;
	localparam logic [RATE_W-1:0] GAIN_RST         = 16'd32768;
	localparam logic [SEED_W-1:0] NOISE_SEED_RST   = 32'd0;

	// Hash and scaling constants
	localparam logic [31:0] MIX_K1    = 32'h7feb352d;
	localparam logic [31:0] MIX_K2    = 32'h846ca68b;
	localparam logic [31:0] HASH_CX   = 32'h9e3779b9;
	localparam logic [31:0] HASH_CY   = 32'h85ebca6b;
	localparam logic [31:0] SEED_STEP = 32'd1013;
	localparam logic [FREQ_W-1:0] FREQ_ONE = 32'h0001_0000;
	localparam logic [FREQ_W-1:0] FREQ_MAX = 32'hFFFF_FFFF;
	localparam logic [AMP_W-1:0]  AMP_ONE  = 17'h1_0000;

	// Per-octave rate settings seen by every cell
	typedef struct packed {
		logic [RATE_W-1:0] lacunarity;
		logic [RATE_W-1:0] gain;
	} fvn_cfg_t;

	// Item as it moves from one octave cell to the next
	typedef struct packed {
		logic               vld;
		logic [COORD_W-1:0] px;
		logic [COORD_W-1:0] py;
		logic [FREQ_W-1:0]  freq;
		logic [AMP_W-1:0]   amp;
		logic [SEED_W-1:0]  seed;
		logic [SUM_W-1:0]   sum;
		logic [NORM_W-1:0]  norm;
	} fvn_oct_t;

endpackage

// ===== src/fvn_if.sv =====
// Handshake channels of the fractal value noise block: sample points in,
// noise values out. Depends on fvn_pkg.
interface fvn_sample_if import fvn_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] px;
	logic signed [COORD_W-1:0] py;

	modport source (output valid, output px, output py, input ready);
	modport sink   (input valid, input px, input py, output ready);
endinterface

interface fvn_result_if import fvn_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [NOISE_W-1:0] noise;

	modport source (output valid, output noise, input ready);
	modport sink   (input valid, input noise, output ready);
endinterface

// ===== src/fvn_cell.sv =====
// One octave cell: scales the point, hashes the four lattice corners,
// interpolates and, when active, accumulates the weighted value over nine
// stages. Depends on fvn_pkg.
module fvn_cell import fvn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     active,
	input  fvn_cfg_t cfg,
	input  fvn_oct_t up_item,
	output fvn_oct_t dn_item
);

	function automatic logic [31:0] mix_head(input logic [31:0] x);
		logic [31:0] y;
		logic [63:0] p;
		y = x ^ (x >> 16);
		p = y * MIX_K1;
		return p[31:0];
	endfunction

	function automatic logic [31:0] mix_mid(input logic [31:0] x);
		logic [31:0] y;
		logic [63:0] p;
		y = x ^ (x >> 15);
		p = y * MIX_K2;
		return p[31:0];
	endfunction

	function automatic logic [31:0] mix_tail(input logic [31:0] x);
		return x ^ (x >> 16);
	endfunction

	// a + floor((b - a) * s / 2^16), same as the weighted sum form
	function automatic logic [FRAC_W-1:0] lerp16(input logic [FRAC_W-1:0] a,
			input logic [FRAC_W-1:0] b, input logic [FRAC_W-1:0] s);
		logic signed [FRAC_W:0]       d;
		logic signed [2*FRAC_W+1:0]   p;
		logic [FRAC_W+1:0]            r;
		d = $signed({1'b0, b}) - $signed({1'b0, a});
		p = d * $signed({1'b0, s});
		r = {2'b00, a} + p[2*FRAC_W+1:FRAC_W];
		return r[FRAC_W-1:0];
	endfunction

	function automatic logic [FRAC_W-1:0] smooth16(input logic [2*FRAC_W-1:0] tt,
			input logic [FRAC_W-1:0] t);
		logic [FRAC_W+1:0]   k;
		logic [3*FRAC_W+1:0] p;
		k = 18'd196608 - {1'b0, t, 1'b0};
		p = tt * k;
		return p[3*FRAC_W-1:2*FRAC_W];
	endfunction

	fvn_oct_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8, out_s9;
	fvn_oct_t nx2, nx6, nx9;

	logic [63:0]           vx_s1, vy_s1;
	logic [FREQ_W+RATE_W-1:0] fp_s1;
	logic [AMP_W-1:0]      an_s1, an_s2, an_s3, an_s4, an_s5, an_s6, an_s7, an_s8;
	logic [31:0]           hx0_s2, hx1_s2, hy0_s2, hy1_s2;
	logic [FRAC_W-1:0]     fx_s2, fy_s2;
	logic [2*FRAC_W-1:0]   ttx_s2, tty_s2;
	logic [31:0]           mx0_s3, mx1_s3, my0_s3, my1_s3;
	logic [31:0]           mx0_s4, mx1_s4, my0_s4, my1_s4;
	logic [FRAC_W-1:0]     sx_s3, sy_s3, sx_s4, sy_s4, sx_s5, sy_s5, sx_s6, sy_s6;
	logic [FRAC_W-1:0]     sy_s7;
	logic [31:0]           c00_s5, c10_s5, c01_s5, c11_s5;
	logic [31:0]           c00_s6, c10_s6, c01_s6, c11_s6;
	logic [FRAC_W-1:0]     a_s7, b_s7, r_s8;

	logic [AMP_W+RATE_W-1:0] amp_prod;
	logic [FREQ_W-1:0]       freq_sat;
	logic [31:0]             gx0, gx1, gy0, gy1;
	logic [31:0]             v00, v10, v01, v11;
	logic [31:0]             x0_cell, y0_cell;
	logic [AMP_W+FRAC_W-1:0] wt;

	// Next amplitude, saturated next frequency, lattice cells, weighted value
	always_comb begin
		amp_prod = up_item.amp * cfg.gain;
		freq_sat = (|fp_s1[FREQ_W+RATE_W-1:FREQ_W+12]) ? FREQ_MAX :
			fp_s1[FREQ_W+11:12];
		x0_cell  = vx_s1[63:32];
		y0_cell  = vy_s1[63:32];
		gx0      = mix_tail(mx0_s4);
		gx1      = mix_tail(mx1_s4);
		gy0      = mix_tail(my0_s4);
		gy1      = mix_tail(my1_s4);
		v00      = mix_tail(c00_s6);
		v10      = mix_tail(c10_s6);
		v01      = mix_tail(c01_s6);
		v11      = mix_tail(c11_s6);
		wt       = it_s8.amp * r_s8;
	end

	// Next carried item at the stages that update a field
	always_comb begin
		nx2      = it_s1;
		nx2.freq = freq_sat;
		nx6      = it_s5;
		nx6.seed = it_s5.seed + SEED_STEP;
		nx9      = it_s8;
		nx9.amp  = an_s8;
		if (active) begin
			nx9.sum  = it_s8.sum + SUM_W'(wt);
			nx9.norm = it_s8.norm + NORM_W'(it_s8.amp);
		end
	end

	// Hold control and the carried item fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_s1  <= '0;
			it_s2  <= '0;
			it_s3  <= '0;
			it_s4  <= '0;
			it_s5  <= '0;
			it_s6  <= '0;
			it_s7  <= '0;
			it_s8  <= '0;
			out_s9 <= '0;
		end else if (adv) begin
			it_s1  <= up_item;
			it_s2  <= nx2;
			it_s3  <= it_s2;
			it_s4  <= it_s3;
			it_s5  <= it_s4;
			it_s6  <= nx6;
			it_s7  <= it_s6;
			it_s8  <= it_s7;
			out_s9 <= nx9;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// scale point, advance rates
			vx_s1 <= 64'($signed(up_item.px) * $signed({1'b0, up_item.freq}));
			vy_s1 <= 64'($signed(up_item.py) * $signed({1'b0, up_item.freq}));
			fp_s1 <= up_item.freq * cfg.lacunarity;
			an_s1 <= amp_prod[AMP_W+RATE_W-1:RATE_W];
			// corner coordinates and fractions
			an_s2  <= an_s1;
			hx0_s2 <= x0_cell + HASH_CX;
			hx1_s2 <= x0_cell + 32'd1 + HASH_CX;
			hy0_s2 <= y0_cell + HASH_CY;
			hy1_s2 <= y0_cell + 32'd1 + HASH_CY;
			fx_s2  <= vx_s1[31:16];
			fy_s2  <= vy_s1[31:16];
			ttx_s2 <= vx_s1[31:16] * vx_s1[31:16];
			tty_s2 <= vy_s1[31:16] * vy_s1[31:16];
			// coordinate mixes, smoothstep
			an_s3  <= an_s2;
			mx0_s3 <= mix_head(hx0_s2);
			mx1_s3 <= mix_head(hx1_s2);
			my0_s3 <= mix_head(hy0_s2);
			my1_s3 <= mix_head(hy1_s2);
			sx_s3  <= smooth16(ttx_s2, fx_s2);
			sy_s3  <= smooth16(tty_s2, fy_s2);
			an_s4  <= an_s3;
			mx0_s4 <= mix_mid(mx0_s3);
			mx1_s4 <= mix_mid(mx1_s3);
			my0_s4 <= mix_mid(my0_s3);
			my1_s4 <= mix_mid(my1_s3);
			sx_s4  <= sx_s3;
			sy_s4  <= sy_s3;
			// combine with seed and mix each corner
			an_s5  <= an_s4;
			c00_s5 <= mix_head(it_s4.seed ^ gx0 ^ gy0);
			c10_s5 <= mix_head(it_s4.seed ^ gx1 ^ gy0);
			c01_s5 <= mix_head(it_s4.seed ^ gx0 ^ gy1);
			c11_s5 <= mix_head(it_s4.seed ^ gx1 ^ gy1);
			sx_s5  <= sx_s4;
			sy_s5  <= sy_s4;
			an_s6  <= an_s5;
			c00_s6 <= mix_mid(c00_s5);
			c10_s6 <= mix_mid(c10_s5);
			c01_s6 <= mix_mid(c01_s5);
			c11_s6 <= mix_mid(c11_s5);
			sx_s6  <= sx_s5;
			sy_s6  <= sy_s5;
			// interpolate along x, then along y
			an_s7 <= an_s6;
			a_s7  <= lerp16(v00[31:16], v10[31:16], sx_s6);
			b_s7  <= lerp16(v01[31:16], v11[31:16], sx_s6);
			sy_s7 <= sy_s6;
			an_s8 <= an_s7;
			r_s8  <= lerp16(a_s7, b_s7, sy_s7);
		end
	end

	assign dn_item = out_s9;

endmodule

// ===== src/fvn_div.sv =====
// Pipelined restoring divider: weighted sum over amplitude total, one
// quotient bit per stage, then the map to signed noise. Depends on fvn_pkg.
module fvn_div import fvn_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  fvn_oct_t                  up_item,
	output logic                      vld,
	output logic signed [NOISE_W-1:0] noise
);

	localparam int Q_W = FRAC_W;

	logic              vld_s [Q_W];
	logic [NORM_W-1:0] rem_s [Q_W];
	logic [NORM_W-1:0] nrm_s [Q_W];
	logic [Q_W-1:0]    low_s [Q_W];
	logic [Q_W-1:0]    quo_s [Q_W];

	for (genvar j = 0; j < Q_W; j++) begin : g_step
		logic              vld_i;
		logic [NORM_W-1:0] rem_i, nrm_i;
		logic [Q_W-1:0]    low_i, quo_i;
		logic [NORM_W:0]   trial, diff;
		logic              ge;

		if (j == 0) begin : g_first
			assign vld_i = up_item.vld;
			assign rem_i = NORM_W'(up_item.sum[SUM_W-1:FRAC_W]);
			assign nrm_i = up_item.norm;
			assign low_i = up_item.sum[FRAC_W-1:0];
			assign quo_i = '0;
		end else begin : g_next
			assign vld_i = vld_s[j-1];
			assign rem_i = rem_s[j-1];
			assign nrm_i = nrm_s[j-1];
			assign low_i = low_s[j-1];
			assign quo_i = quo_s[j-1];
		end

		// Shift in the next dividend bit and subtract where it fits
		always_comb begin
			trial = {rem_i, low_i[Q_W-1]};
			diff  = trial - {1'b0, nrm_i};
			ge    = (trial >= {1'b0, nrm_i});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv) begin
				vld_s[j] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= ge ? diff[NORM_W-1:0] : trial[NORM_W-1:0];
				nrm_s[j] <= nrm_i;
				low_s[j] <= {low_i[Q_W-2:0], 1'b0};
				quo_s[j] <= {quo_i[Q_W-2:0], ge};
			end
		end
	end

	// Map [0,1) to [-1,1): flip the top bit; no octaves gives zero
	assign vld   = vld_s[Q_W-1];
	assign noise = (nrm_s[Q_W-1] == '0) ? '0 :
		$signed({~quo_s[Q_W-1][Q_W-1], quo_s[Q_W-1][Q_W-2:0]});

endmodule

// ===== src/fractal_value_noise_2d.sv =====
// Fractal value noise of a 2D point: a chain of eight octave cells, each
// nine stages deep, followed by a sixteen-stage divider. One point is taken
// every cycle while no result is held back; the depth of the pipeline is set
// by the hash multipliers of each cell and the one-bit-per-stage division.
// When a result is held back the whole pipeline stops and no point is taken.
// Octaves beyond octave_count add nothing to the sum or the amplitude total;
// there is no start-up pass after reset.
// Depends on fvn_pkg, fvn_if, fvn_cell and fvn_div.
module fractal_value_noise_2d import fvn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fvn_sample_if.sink            sample,
	fvn_result_if.source          result
);

	logic [OCT_W-1:0]  octave_count_q;
	logic [RATE_W-1:0] lacunarity_q;
	logic [RATE_W-1:0] gain_q;
	logic [SEED_W-1:0] noise_seed_q;

	fvn_cfg_t cfg;
	fvn_oct_t lnk [MAX_OCTAVES+1];
	logic     adv;
	logic     out_vld;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= OCTAVE_COUNT_RST;
			lacunarity_q   <= LACUNARITY_RST;
			gain_q         <= GAIN_RST;
			noise_seed_q   <= NOISE_SEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_OCTAVE_COUNT: octave_count_q <= cfg_data[OCT_W-1:0];
				REG_LACUNARITY:   lacunarity_q   <= cfg_data[RATE_W-1:0];
				REG_GAIN:         gain_q         <= cfg_data[RATE_W-1:0];
				REG_NOISE_SEED:   noise_seed_q   <= cfg_data[SEED_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance everything unless a finished item waits
	assign adv          = !out_vld || result.ready;
	assign sample.ready = adv;

	assign cfg.lacunarity = lacunarity_q;
	assign cfg.gain       = gain_q;

	// Start of the octave chain
	always_comb begin
		lnk[0].vld  = sample.valid;
		lnk[0].px   = sample.px;
		lnk[0].py   = sample.py;
		lnk[0].freq = FREQ_ONE;
		lnk[0].amp  = AMP_ONE;
		lnk[0].seed = noise_seed_q;
		lnk[0].sum  = '0;
		lnk[0].norm = '0;
	end

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		fvn_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.active  (OCT_W'(i) < octave_count_q),
			.cfg     (cfg),
			.up_item (lnk[i]),
			.dn_item (lnk[i+1])
		);
	end

	fvn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.up_item (lnk[MAX_OCTAVES]),
		.vld     (out_vld),
		.noise   (result.noise)
	);

	assign result.valid = out_vld;

endmodule

// ===== src/fvn_chk.sv =====
// Port checker for the fractal value noise block, bound to the top level.
// Depends on fvn_pkg and on the top level's ports.
module fvn_chk import fvn_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [NOISE_W-1:0] noise
);

	// A held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(noise))
		else $error("result changed while stalled");

	// With no result waiting, the input is always ready
	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with empty output");

	// A stalled result stops intake
	a_stall_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// No result during reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind fractal_value_noise_2d fvn_chk u_fvn_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.noise     (result.noise)
);

// ===== sim/fractal_value_noise_2d_tb.sv =====
// Self-checking testbench for fractal_value_noise_2d: drives sample points and
// register writes, predicts each noise value and checks every result item.
// Depends on fvn_pkg, fvn_if and the block itself.
module fractal_value_noise_2d_tb;
	import fvn_pkg::*;

	// Noise predictor and store of expected noise values
	class noise_scoreboard;
		logic [OCT_W-1:0]    octaves;
		logic [RATE_W-1:0]   lacun;
		logic [RATE_W-1:0]   gain_q;
		logic [SEED_W-1:0]   seed_q;
		logic signed [NOISE_W-1:0] pending_noise[$];
		int                  errors;

		function new();
			octaves = OCTAVE_COUNT_RST;
			lacun   = LACUNARITY_RST;
			gain_q  = GAIN_RST;
			seed_q  = NOISE_SEED_RST;
			errors  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_OCTAVE_COUNT: octaves = data[OCT_W-1:0];
				REG_LACUNARITY:   lacun   = data[RATE_W-1:0];
				REG_GAIN:         gain_q  = data[RATE_W-1:0];
				REG_NOISE_SEED:   seed_q  = data[SEED_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] mix(logic [31:0] x);
			x = x ^ (x >> 16);
			x = x * MIX_K1;
			x = x ^ (x >> 15);
			x = x * MIX_K2;
			x = x ^ (x >> 16);
			return x;
		endfunction

		function logic [15:0] lattice(logic [31:0] cx, logic [31:0] cy, logic [31:0] sd);
			logic [31:0] h;
			h = sd ^ mix(cx + HASH_CX) ^ mix(cy + HASH_CY);
			h = mix(h);
			return h[31:16];
		endfunction

		function logic [63:0] smooth(logic [63:0] t);
			logic [63:0] tt;
			tt = t * t;
			return (tt * (64'd196608 - 2 * t)) >> 32;
		endfunction

		function logic [63:0] blend(logic [63:0] a, logic [63:0] b, logic [63:0] s);
			return (a * (64'd65536 - s) + b * s) >> 16;
		endfunction

		// Scale a Q16.16 coordinate: cell from bits 63..32, fraction from 31..16
		function void scale(logic [31:0] p, logic [31:0] freq,
				output logic [31:0] lat_c, output logic [63:0] frac);
			logic [63:0] v;
			v = (p[31] ? {32'd0, -p} : {32'd0, p}) * {32'd0, freq};
			if (p[31])
				v = -v;
			lat_c = v[63:32];
			frac  = {48'd0, v[31:16]};
		endfunction

		function logic [63:0] octave_value(logic [31:0] px, logic [31:0] py,
				logic [31:0] freq, logic [31:0] sd);
			logic [31:0] x0, y0;
			logic [63:0] fx, fy, sx, sy, a, b;
			scale(px, freq, x0, fx);
			scale(py, freq, y0, fy);
			sx = smooth(fx);
			sy = smooth(fy);
			a = blend(64'(lattice(x0, y0, sd)), 64'(lattice(x0 + 1, y0, sd)), sx);
			b = blend(64'(lattice(x0, y0 + 1, sd)), 64'(lattice(x0 + 1, y0 + 1, sd)),
				sx);
			return blend(a, b, sy);
		endfunction

		// Note an accepted point and queue its expected noise
		function void note_point(logic [31:0] px, logic [31:0] py);
			logic [63:0] amp, freq, sum, norm, r;
			int n;
			logic signed [NOISE_W-1:0] res;
			n = (octaves > MAX_OCTAVES) ? MAX_OCTAVES : octaves;
			amp = 65536; freq = 65536; sum = 0; norm = 0; res = 0;
			for (int i = 0; i < n; i++) begin
				sum += amp * octave_value(px, py, freq[31:0], seed_q + i * SEED_STEP);
				norm += amp;
				amp = (amp * gain_q) >> 16;
				freq = (freq * lacun) >> 12;
				if (freq > 64'hFFFF_FFFF)
					freq = 64'hFFFF_FFFF;
			end
			if (norm != 0) begin
				r = sum / norm;
				res = (r >= 65535) ? 16'sd32767 : NOISE_W'(r - 32768);
			end
			pending_noise.push_back(res);
		endfunction

		// Compare a result item with the oldest expectation
		function void check_noise(logic signed [NOISE_W-1:0] got);
			logic signed [NOISE_W-1:0] want;
			if (pending_noise.size() == 0) begin
				$error("noise: unexpected result %0d", got);
				errors++;
				return;
			end
			want = pending_noise.pop_front();
			if (got !== want) begin
				$error("noise: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;
	noise_scoreboard sb;

	fvn_sample_if sample_ch ();
	fvn_result_if result_ch ();

	fractal_value_noise_2d dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.sample   (sample_ch.sink),
		.result   (result_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side at random, or hold it off completely
	always @(negedge clk) begin
		result_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
	end

	// Check every accepted result item
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_noise(result_ch.noise);
	end

	// Offer one point, idling at random first; called and returns at a falling edge
	task automatic send_point(logic [31:0] x, logic [31:0] y);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.px    <= x;
		sample_ch.py    <= y;
		do @(posedge clk); while (!sample_ch.ready);
		sb.note_point(x, y);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		sample_ch.valid <= 1'b0;
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic set_regs(logic [3:0] oc, logic [15:0] lac, logic [15:0] g, logic [31:0] sd);
		write_reg(REG_OCTAVE_COUNT, CFG_DATA_W'(oc));
		write_reg(REG_LACUNARITY, CFG_DATA_W'(lac));
		write_reg(REG_GAIN, CFG_DATA_W'(g));
		write_reg(REG_NOISE_SEED, sd);
	endtask

	// Wait until every expected result is in, then let the pipeline settle
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (sb.pending_noise.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(2 * 8 * 65536)) - 8 * 65536);
			2: return 32'($signed($urandom_range(2 * 256 * 65536)) - 256 * 65536);
			default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
		endcase
	endfunction

	task automatic send_random(int count);
		repeat (count) send_point(rand_coord(), rand_coord());
	endtask

	task automatic send_directed();
		send_point(32'h0000_0000, 32'h0000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000);
		send_point(32'h7FFF_FFFF, 32'h8000_0000);
		send_point(32'hFFFF_FFFF, 32'h0000_0001);
		send_point(32'h0000_8000, 32'hFFFF_8000);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		hold_off = 1'b0;
		send_idle_pct = 29;
		recv_idle_pct = 63;
		sample_ch.valid = 1'b0;
		sample_ch.px = '0;
		sample_ch.py = '0;
		result_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings, extremes of the point fields
		send_directed();
		drain();
		// Zero octaves
		set_regs(4'd0, 16'd8192, 16'd32768, 32'd0);
		send_directed();
		drain();
		// Octave count above the maximum, frequency overflow, seed wrap
		set_regs(4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_directed();
		drain();
		// Zero lacunarity and zero gain
		set_regs(4'd8, 16'd0, 16'd0, 32'h1234_5678);
		send_directed();
		send_random(150);
		drain();

		set_regs(4'd1, 16'd4096, 16'd65535, $urandom());
		send_random(150);
		drain();

		// Swap the idling sides
		send_idle_pct = 63;
		recv_idle_pct = 29;
		set_regs(4'd8, 16'd8192, 16'd32768, 32'd0);
		send_random(150);
		drain();
		set_regs(4'($urandom_range(8)), 16'($urandom()), 16'($urandom()), $urandom());
		send_random(150);
		drain();

		// No idling; hold off the result side so the pipeline fills up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_regs(4'd5, 16'hFFFF, 16'd0, $urandom());
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(negedge clk);
				hold_off = 1'b0;
			end
			send_random(150);
		join
		drain();
		set_regs(4'($urandom_range(15)), 16'($urandom()), 16'($urandom()), $urandom());
		send_random(276);
		drain();

		if (sb.pending_noise.size() != 0) begin
			$error("noise: %0d expected results never arrived", sb.pending_noise.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("PASS fractal_value_noise_2d");
		end else begin
			$display("FAIL fractal_value_noise_2d");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#5_000_000;
		$display("FAIL fractal_value_noise_2d");
		$finish;
	end

endmodule

// ===== sim.f =====
src/fvn_pkg.sv
src/fvn_if.sv
src/fvn_cell.sv
src/fvn_div.sv
src/fractal_value_noise_2d.sv
src/fvn_chk.sv
sim/fractal_value_noise_2d_tb.sv
